>>> src/dual_incremental_pi_motor_drive_macros.svh
// assertion macros for the dual wheel pi motor drive checker
`ifndef DUAL_INCREMENTAL_PI_MOTOR_DRIVE_MACROS_SVH
`define DUAL_INCREMENTAL_PI_MOTOR_DRIVE_MACROS_SVH

// same-cycle implication
`define DIPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dipm assertion failed");

// next-cycle implication
`define DIPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dipm assertion failed");

`endif

>>> src/dipm_pkg.sv
// types and constants shared by the dual wheel pi motor drive
package dipm_pkg;

  localparam logic [15:0] PROP_GAIN_RST      = 16'd0;
  localparam logic [15:0] INTEG_GAIN_RST     = 16'd0;
  localparam logic [14:0] DRIVE_LIMIT_RST    = 15'd6000;
  localparam logic [14:0] DEAD_BAND_RST      = 15'd3600;
  localparam logic [15:0] ENCODER_OFFSET_RST = 16'd10000;
  localparam logic [15:0] STEER_CENTER_RST   = 16'd2800;
  localparam logic [14:0] STEER_SPAN_RST     = 15'd2000;

  // width of prop and integ products added together
  localparam int STEP_W = 37;

  typedef enum logic [2:0] {
    CFG_PROP_GAIN      = 3'd0,
    CFG_INTEG_GAIN     = 3'd1,
    CFG_DRIVE_LIMIT    = 3'd2,
    CFG_DEAD_BAND      = 3'd3,
    CFG_ENCODER_OFFSET = 3'd4,
    CFG_STEER_CENTER   = 3'd5,
    CFG_STEER_SPAN     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [14:0] drive_limit;
    logic [14:0] dead_band;
    logic [15:0] encoder_offset;
    logic [15:0] steer_center;
    logic [14:0] steer_span;
  } cfg_t;

  typedef struct packed {
    logic acc1;
    logic mv2;
    logic mv3;
    logic mv4;
  } pipe_ctl_t;

endpackage

>>> src/dipm_cfg.sv
// configuration register file
module dipm_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  dipm_pkg::cfg_idx_e   cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output dipm_pkg::cfg_t       cfg_o
);
  import dipm_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PROP_GAIN:      cfg_d.prop_gain      = cfg_data_i;
        CFG_INTEG_GAIN:     cfg_d.integ_gain     = cfg_data_i;
        CFG_DRIVE_LIMIT:    cfg_d.drive_limit    = cfg_data_i[14:0];
        CFG_DEAD_BAND:      cfg_d.dead_band      = cfg_data_i[14:0];
        CFG_ENCODER_OFFSET: cfg_d.encoder_offset = cfg_data_i;
        CFG_STEER_CENTER:   cfg_d.steer_center   = cfg_data_i;
        CFG_STEER_SPAN:     cfg_d.steer_span     = cfg_data_i[14:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= PROP_GAIN_RST;
      cfg_q.integ_gain     <= INTEG_GAIN_RST;
      cfg_q.drive_limit    <= DRIVE_LIMIT_RST;
      cfg_q.dead_band      <= DEAD_BAND_RST;
      cfg_q.encoder_offset <= ENCODER_OFFSET_RST;
      cfg_q.steer_center   <= STEER_CENTER_RST;
      cfg_q.steer_span     <= STEER_SPAN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> src/dipm_lane.sv
// one wheel lane: error, products and saturating accumulator
module dipm_lane #(
  parameter int ACCUM_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dipm_pkg::pipe_ctl_t           ctl_i,
  input  dipm_pkg::cfg_t                cfg_i,
  input  logic signed [15:0]            goal_i,
  input  logic signed [16:0]            speed_i,
  output logic signed [ACCUM_BITS-1:0]  accum_o
);
  import dipm_pkg::*;

  localparam int SUM_W = ((ACCUM_BITS > STEP_W) ? ACCUM_BITS : STEP_W) + 1;
  localparam int HI_W  = SUM_W - ACCUM_BITS + 1;

  logic signed [17:0]           err_d, err_q, prev_q;
  logic signed [18:0]           diff_d, diff_q;
  logic signed [35:0]           pprod_d, pprod_q;
  logic signed [34:0]           iprod_d, iprod_q;
  logic signed [SUM_W-1:0]      sum_w;
  logic [HI_W-1:0]              hi_bits;
  logic                         in_range;
  logic signed [ACCUM_BITS-1:0] accum_d, accum_q;

  assign err_d   = 18'(goal_i) - 18'(speed_i);
  assign diff_d  = 19'(err_d) - 19'(prev_q);
  assign pprod_d = $signed({1'b0, cfg_i.prop_gain}) * diff_q;
  assign iprod_d = $signed({1'b0, cfg_i.integ_gain}) * err_q;

  assign sum_w    = SUM_W'(accum_q) + SUM_W'(pprod_q) + SUM_W'(iprod_q);
  assign hi_bits  = sum_w[SUM_W-1:ACCUM_BITS-1];
  assign in_range = (&hi_bits) || (~|hi_bits);

  always_comb begin
    if (in_range) begin
      accum_d = sum_w[ACCUM_BITS-1:0];
    end else if (sum_w[SUM_W-1]) begin
      accum_d = {1'b1, {(ACCUM_BITS-1){1'b0}}};
    end else begin
      accum_d = {1'b0, {(ACCUM_BITS-1){1'b1}}};
    end
  end

  assign accum_o = accum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      accum_q <= '0;
    end else begin
      if (ctl_i.acc1) begin
        prev_q <= err_d;
      end
      if (ctl_i.mv3) begin
        accum_q <= accum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc1) begin
      err_q  <= err_d;
      diff_q <= diff_d;
    end
    if (ctl_i.mv2) begin
      pprod_q <= pprod_d;
      iprod_q <= iprod_d;
    end
  end

endmodule

>>> src/dipm_merge.sv
// merge stage: drive clamp and deadband, steering clamp, output register
module dipm_merge #(
  parameter int ACCUM_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dipm_pkg::pipe_ctl_t           ctl_i,
  input  dipm_pkg::cfg_t                cfg_i,
  input  logic signed [16:0]            left_vel_i,
  input  logic signed [16:0]            right_vel_i,
  input  logic [15:0]                   steer_request_i,
  input  logic signed [ACCUM_BITS-1:0]  left_accum_i,
  input  logic signed [ACCUM_BITS-1:0]  right_accum_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic signed [15:0]            left_drive_o,
  output logic signed [15:0]            right_drive_o,
  output logic [15:0]                   steer_drive_o,
  output logic signed [16:0]            left_vel_o,
  output logic signed [16:0]            right_vel_o
);
  import dipm_pkg::*;

  function automatic logic signed [15:0] drive_clamp(
    input logic signed [ACCUM_BITS-1:0] acc,
    input logic [14:0]                  lim,
    input logic [14:0]                  db
  );
    logic signed [ACCUM_BITS-1:0] lim_w;
    logic signed [16:0]           d;
    logic signed [16:0]           db_w;
    lim_w = $signed(ACCUM_BITS'(lim));
    db_w  = $signed({2'b00, db});
    if (acc > lim_w) begin
      d = $signed({2'b00, lim});
    end else if (acc < -lim_w) begin
      d = -$signed({2'b00, lim});
    end else begin
      d = $signed(acc[16:0]);
    end
    if (d > -db_w && d < db_w) begin
      d = '0;
    end
    return d[15:0];
  endfunction

  logic signed [17:0] lo_w, hi_w, req_w;
  logic [15:0]        steer_d;
  logic [15:0]        steer1_q, steer2_q, steer3_q;
  logic signed [16:0] lspd1_q, lspd2_q, lspd3_q;
  logic signed [16:0] rspd1_q, rspd2_q, rspd3_q;
  logic               out_valid_d, out_valid_q;

  assign lo_w  = $signed({2'b00, cfg_i.steer_center}) - $signed({3'b000, cfg_i.steer_span});
  assign hi_w  = $signed({2'b00, cfg_i.steer_center}) + $signed({3'b000, cfg_i.steer_span});
  assign req_w = $signed({2'b00, steer_request_i});

  always_comb begin
    steer_d = steer_request_i;
    if (req_w < lo_w) begin
      steer_d = lo_w[15:0];
    end
    if (req_w > hi_w) begin
      steer_d = hi_w[15:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.mv4) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc1) begin
      steer1_q <= steer_d;
      lspd1_q  <= left_vel_i;
      rspd1_q  <= right_vel_i;
    end
    if (ctl_i.mv2) begin
      steer2_q <= steer1_q;
      lspd2_q  <= lspd1_q;
      rspd2_q  <= rspd1_q;
    end
    if (ctl_i.mv3) begin
      steer3_q <= steer2_q;
      lspd3_q  <= lspd2_q;
      rspd3_q  <= rspd2_q;
    end
    if (ctl_i.mv4) begin
      left_drive_o  <= drive_clamp(left_accum_i, cfg_i.drive_limit, cfg_i.dead_band);
      right_drive_o <= drive_clamp(right_accum_i, cfg_i.drive_limit, cfg_i.dead_band);
      steer_drive_o <= steer3_q;
      left_vel_o    <= lspd3_q;
      right_vel_o   <= rspd3_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/dual_incremental_pi_motor_drive.sv
// top level: dual wheel incremental pi motor drive
// path: error, product and accumulator registers, then the output register
// throughput: one transaction per cycle while unstalled, set by the per-lane
// accumulator loop; stages advance alone so bubbles collapse under output stall
// reset: asynchronous active low; clears accumulators, previous errors, valids
// and loads the configuration defaults
module dual_incremental_pi_motor_drive #(
  parameter int ACCUM_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  dipm_pkg::cfg_idx_e   cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [15:0]          right_count_i,
  input  logic [15:0]          left_count_i,
  input  logic signed [15:0]   right_goal_i,
  input  logic signed [15:0]   left_goal_i,
  input  logic [15:0]          steer_request_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   left_drive_o,
  output logic signed [15:0]   right_drive_o,
  output logic [15:0]          steer_drive_o,
  output logic signed [16:0]   left_vel_o,
  output logic signed [16:0]   right_vel_o
);
  import dipm_pkg::*;

  cfg_t                         cfg;
  pipe_ctl_t                    ctl;
  logic                         v1_q, v2_q, v3_q;
  logic                         rdy1, rdy2, rdy3, out_free;
  logic signed [16:0]           lspeed, rspeed;
  logic signed [ACCUM_BITS-1:0] lacc, racc;

  assign out_free = !out_valid_o || !out_stall_i;
  assign rdy3     = !v3_q || out_free;
  assign rdy2     = !v2_q || rdy3;
  assign rdy1     = !v1_q || rdy2;

  assign in_stall_o = !rdy1;
  assign ctl.acc1   = in_valid_i && rdy1;
  assign ctl.mv2    = v1_q && rdy2;
  assign ctl.mv3    = v2_q && rdy3;
  assign ctl.mv4    = v3_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign rspeed = $signed({1'b0, right_count_i}) - $signed({1'b0, cfg.encoder_offset});
  assign lspeed = $signed({1'b0, cfg.encoder_offset}) - $signed({1'b0, left_count_i});

  dipm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dipm_lane #(.ACCUM_BITS(ACCUM_BITS)) u_lane_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .cfg_i   (cfg),
    .goal_i  (left_goal_i),
    .speed_i (lspeed),
    .accum_o (lacc)
  );

  dipm_lane #(.ACCUM_BITS(ACCUM_BITS)) u_lane_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .cfg_i   (cfg),
    .goal_i  (right_goal_i),
    .speed_i (rspeed),
    .accum_o (racc)
  );

  dipm_merge #(.ACCUM_BITS(ACCUM_BITS)) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .cfg_i           (cfg),
    .left_vel_i      (lspeed),
    .right_vel_i     (rspeed),
    .steer_request_i (steer_request_i),
    .left_accum_i    (lacc),
    .right_accum_i   (racc),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .left_drive_o    (left_drive_o),
    .right_drive_o   (right_drive_o),
    .steer_drive_o   (steer_drive_o),
    .left_vel_o      (left_vel_o),
    .right_vel_o     (right_vel_o)
  );

endmodule

>>> src/dipm_checker.sv
// port level checker for the dual wheel pi motor drive, with bind
`include "dual_incremental_pi_motor_drive_macros.svh"

module dipm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] left_drive_o,
  input logic signed [15:0] right_drive_o,
  input logic [15:0]        steer_drive_o,
  input logic signed [16:0] left_vel_o,
  input logic signed [16:0] right_vel_o
);

  // output transaction holds while stalled
  `DIPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `DIPM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(left_drive_o) && $stable(right_drive_o) && $stable(steer_drive_o) && $stable(left_vel_o) && $stable(right_vel_o))

  // input never stalls unless the output register is blocked
  `DIPM_ASSERT_IMPLY(a_in_free, clk_i, rst_ni, !(out_valid_o && out_stall_i), !in_stall_o)

  // drive magnitude is bounded by a 15 bit limit
  `DIPM_ASSERT_IMPLY(a_drive_range, clk_i, rst_ni, out_valid_o, (left_drive_o != 16'sh8000) && (right_drive_o != 16'sh8000))

endmodule

bind dual_incremental_pi_motor_drive dipm_checker u_dipm_checker (.*);
